/* hw/rtl/uart_frame_receiver_defines.svh */
// Assertion helpers shared by the receiver RTL.
`ifndef UART_FRAME_RECEIVER_DEFINES_SVH
`define UART_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UFR_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("uart_frame_receiver: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define UFR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("uart_frame_receiver: next-cycle check failed");

`endif

/* hw/rtl/ufr_pkg.sv */
package ufr_pkg;

    localparam int PERIOD_W     = 20;
    localparam int TPM_W        = 20;
    localparam int TIMEOUT_MS_W = 16;
    localparam int LIMIT_W      = PERIOD_W + TIMEOUT_MS_W;
    localparam int BIT_INDEX_W  = 4;
    localparam int SHIFT_W      = 9;
    localparam int DATA_W       = 8;
    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;

    localparam int MAX_FRAME_BITS   = 11;
    localparam int MAX_PAYLOAD_BITS = MAX_FRAME_BITS - 2;
    localparam int DATA_BITS_SEVEN  = 7;
    localparam int DATA_BITS_EIGHT  = 8;

    localparam logic [1:0] PARITY_EVEN = 2'd1;
    localparam logic [1:0] PARITY_ODD  = 2'd2;

    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RESET = 20'd9615;
    localparam logic [TPM_W-1:0]    TPM_RESET        = 20'd100000;
    localparam logic                DATA_BITS_RESET  = 1'b1;
    localparam logic [1:0]          PARITY_RESET     = 2'd0;

    typedef enum logic [1:0] {
        REG_BIT_PERIOD   = 2'd0,
        REG_TICKS_PER_MS = 2'd1,
        REG_DATA_BITS    = 2'd2,
        REG_PARITY       = 2'd3
    } ufr_reg_idx_t;

    typedef enum logic [1:0] {
        PH_IDLE         = 2'd0,
        PH_HUNT_TIMED   = 2'd1,
        PH_HUNT_FOREVER = 2'd2,
        PH_RECEIVE      = 2'd3
    } ufr_phase_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_FRAME_ERROR  = 2'd1,
        ST_PARITY_ERROR = 2'd2,
        ST_TIMEOUT      = 2'd3
    } ufr_status_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] bit_period_ticks;
        logic [TPM_W-1:0]    ticks_per_ms;
        logic                data_bits_mode;
        logic [1:0]          parity_mode;
    } ufr_cfg_t;

    typedef struct packed {
        ufr_status_t       status;
        logic [DATA_W-1:0] data;
    } ufr_result_t;

endpackage

/* hw/rtl/uart_frame_receiver.sv */
// Channel   Direction  Ports                                         Moves
// s_        in         s_valid/s_ready, operation, line, timeout     one tick or start
// m_        out        m_valid/m_ready, status, received_data        one receive result
// APB       in/out     psel, penable, pwrite, paddr, pwdata, prdata  register access
//
// Each transfer is handled in its accepting cycle: one item per clock unless stalled.
// A result goes into a two-entry queue; s_ready drops only while both entries wait.
// Synchronous active-low reset restores register defaults and leaves the receiver idle.
// Registers are read live on every tick and should be written while no receive is armed.
`include "uart_frame_receiver_defines.svh"

module uart_frame_receiver (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ufr_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ufr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ufr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    // Input channel.
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_operation,
    input  logic                             s_line_level,
    input  logic [ufr_pkg::TIMEOUT_MS_W-1:0] s_timeout_ms,
    // Result channel.
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_status,
    output logic [ufr_pkg::DATA_W-1:0]       m_received_data
);
    import ufr_pkg::*;

    ufr_cfg_t    cfg;
    ufr_result_t res_data;
    ufr_result_t head;
    logic        res_push;
    logic        in_fire;
    logic        queue_full;

    // The register block decodes paddr[3:2]; every write address maps to one register.
    ufr_config_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // A transfer is accepted whenever the result queue has room for a possible result.
    assign s_ready = !queue_full;
    assign in_fire = s_valid && s_ready;

    // The frame core turns one accepted transfer into its state update and at most
    // one result, all within the accepting cycle.
    ufr_frame_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .in_fire       (in_fire),
        .in_operation  (s_operation),
        .in_line_level (s_line_level),
        .in_timeout_ms (s_timeout_ms),
        .res_push      (res_push),
        .res_data      (res_data)
    );

    // Results wait here so a stalled consumer does not stop the tick stream at once.
    ufr_result_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res_data),
        .pop       (m_valid && m_ready),
        .not_empty (m_valid),
        .full      (queue_full),
        .head      (head)
    );

    assign m_status        = head.status;
    assign m_received_data = head.data;

    `UFR_ASSERT_SAME(a_stall_needs_backlog, aclk, aresetn, !s_ready, m_valid)
    `UFR_ASSERT_SAME(a_error_data_zero, aclk, aresetn, m_valid && (m_status != ST_OK), m_received_data == '0)
    `UFR_ASSERT_SAME(a_start_no_result, aclk, aresetn, in_fire && s_operation, !res_push)
    `UFR_ASSERT_NEXT(a_push_shows_valid, aclk, aresetn, res_push, m_valid)

endmodule

/* hw/rtl/ufr_config_regs.sv */
module ufr_config_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ufr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ufr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ufr_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output ufr_pkg::ufr_cfg_t              cfg
);
    import ufr_pkg::*;

    ufr_cfg_t     cfg_reg, cfg_next;
    ufr_reg_idx_t reg_idx;
    logic         wr_en;

    assign pready  = 1'b1;
    assign reg_idx = ufr_reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_BIT_PERIOD:   cfg_next.bit_period_ticks = pwdata[PERIOD_W-1:0];
                REG_TICKS_PER_MS: cfg_next.ticks_per_ms     = pwdata[TPM_W-1:0];
                REG_DATA_BITS:    cfg_next.data_bits_mode   = pwdata[0];
                REG_PARITY:       cfg_next.parity_mode      = pwdata[1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BIT_PERIOD:   prdata = APB_DATA_W'(cfg_reg.bit_period_ticks);
            REG_TICKS_PER_MS: prdata = APB_DATA_W'(cfg_reg.ticks_per_ms);
            REG_DATA_BITS:    prdata = APB_DATA_W'(cfg_reg.data_bits_mode);
            REG_PARITY:       prdata = APB_DATA_W'(cfg_reg.parity_mode);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bit_period_ticks <= BIT_PERIOD_RESET;
            cfg_reg.ticks_per_ms     <= TPM_RESET;
            cfg_reg.data_bits_mode   <= DATA_BITS_RESET;
            cfg_reg.parity_mode      <= PARITY_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hw/rtl/ufr_frame_core.sv */
module ufr_frame_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  ufr_pkg::ufr_cfg_t                cfg,
    input  logic                             in_fire,
    input  logic                             in_operation,
    input  logic                             in_line_level,
    input  logic [ufr_pkg::TIMEOUT_MS_W-1:0] in_timeout_ms,
    output logic                             res_push,
    output ufr_pkg::ufr_result_t             res_data
);
    import ufr_pkg::*;

    ufr_phase_t             phase_reg, phase_next;
    logic [LIMIT_W-1:0]     limit_reg, limit_next;
    logic [LIMIT_W-1:0]     elapsed_reg, elapsed_next;
    logic [PERIOD_W-1:0]    btc_reg, btc_next;
    logic [BIT_INDEX_W-1:0] bit_index_reg, bit_index_next;
    logic [SHIFT_W-1:0]     shift_reg, shift_next;
    logic                   parity_reg, parity_next;

    logic [PERIOD_W-1:0]    period;
    logic [PERIOD_W-1:0]    quarter;
    logic                   parity_on;
    logic [BIT_INDEX_W-1:0] n_raw, n_bits;
    logic [SHIFT_W-1:0]     top_bit, masked;
    logic [DATA_W-1:0]      ok_data;
    logic                   timeout_hit, sample_due, stop_slot, frame_done;

    assign period    = (cfg.bit_period_ticks == '0) ? PERIOD_W'(1) : cfg.bit_period_ticks;
    assign quarter   = {2'b00, period[PERIOD_W-1:2]};
    assign parity_on = (cfg.parity_mode == PARITY_EVEN) || (cfg.parity_mode == PARITY_ODD);
    assign n_raw     = (cfg.data_bits_mode ? BIT_INDEX_W'(DATA_BITS_EIGHT)
                                           : BIT_INDEX_W'(DATA_BITS_SEVEN))
                       + BIT_INDEX_W'(parity_on);
    assign n_bits    = (n_raw > BIT_INDEX_W'(MAX_PAYLOAD_BITS)) ? BIT_INDEX_W'(MAX_PAYLOAD_BITS)
                                                                : n_raw;
    // Payload bits enter at the top and shift down, so the last one lands at n-1.
    assign top_bit   = SHIFT_W'(1) << (n_bits - BIT_INDEX_W'(1));
    assign masked    = shift_reg & ~top_bit;
    assign ok_data   = parity_on ? masked[DATA_W-1:0] : shift_reg[DATA_W-1:0];

    assign timeout_hit = (phase_reg == PH_HUNT_TIMED) && (elapsed_reg >= limit_reg);
    assign sample_due  = (phase_reg == PH_RECEIVE) && (btc_reg[PERIOD_W-1:1] == '0);
    assign stop_slot   = bit_index_reg > n_bits;
    assign frame_done  = sample_due && ((bit_index_reg == '0) ? in_line_level : stop_slot);

    always_comb begin
        phase_next = phase_reg;
        if (in_fire) begin
            if (in_operation) begin
                phase_next = (in_timeout_ms == '0) ? PH_HUNT_FOREVER : PH_HUNT_TIMED;
            end else begin
                unique case (phase_reg) inside
                    PH_IDLE: phase_next = PH_IDLE;
                    PH_HUNT_TIMED, PH_HUNT_FOREVER: begin
                        if (timeout_hit) begin
                            phase_next = PH_IDLE;
                        end else if (!in_line_level) begin
                            phase_next = PH_RECEIVE;
                        end
                    end
                    PH_RECEIVE: begin
                        if (frame_done) begin
                            phase_next = PH_IDLE;
                        end
                    end
                endcase
            end
        end
    end

    always_comb begin
        limit_next      = limit_reg;
        elapsed_next    = elapsed_reg;
        btc_next        = btc_reg;
        bit_index_next  = bit_index_reg;
        shift_next      = shift_reg;
        parity_next     = parity_reg;
        res_push        = 1'b0;
        res_data.status = ST_OK;
        res_data.data   = '0;
        if (in_fire) begin
            if (in_operation) begin
                limit_next     = LIMIT_W'(cfg.ticks_per_ms) * LIMIT_W'(in_timeout_ms);
                elapsed_next   = '0;
                btc_next       = '0;
                bit_index_next = '0;
                shift_next     = '0;
                parity_next    = 1'b0;
            end else begin
                unique case (phase_reg) inside
                    PH_IDLE: begin
                        res_push = 1'b0;
                    end
                    PH_HUNT_TIMED, PH_HUNT_FOREVER: begin
                        if (timeout_hit) begin
                            res_push        = 1'b1;
                            res_data.status = ST_TIMEOUT;
                        end else if (!in_line_level) begin
                            shift_next  = '0;
                            parity_next = (cfg.parity_mode == PARITY_ODD);
                            // With a quarter period of zero the detecting tick is
                            // itself the start bit sample, and it reads low.
                            if (quarter == '0) begin
                                bit_index_next = BIT_INDEX_W'(1);
                                btc_next       = period;
                            end else begin
                                bit_index_next = '0;
                                btc_next       = quarter;
                            end
                        end else if (phase_reg == PH_HUNT_TIMED) begin
                            elapsed_next = elapsed_reg + LIMIT_W'(1);
                        end
                    end
                    PH_RECEIVE: begin
                        if (!sample_due) begin
                            btc_next = btc_reg - PERIOD_W'(1);
                        end else begin
                            btc_next = period;
                            if (bit_index_reg == '0) begin
                                if (in_line_level) begin
                                    res_push        = 1'b1;
                                    res_data.status = ST_FRAME_ERROR;
                                end else begin
                                    bit_index_next = BIT_INDEX_W'(1);
                                end
                            end else if (!stop_slot) begin
                                shift_next     = {1'b0, shift_reg[SHIFT_W-1:1]}
                                                 | (in_line_level ? top_bit : '0);
                                parity_next    = parity_reg ^ in_line_level;
                                bit_index_next = bit_index_reg + BIT_INDEX_W'(1);
                            end else begin
                                res_push = 1'b1;
                                if (!in_line_level) begin
                                    res_data.status = ST_FRAME_ERROR;
                                end else if (parity_on && parity_reg) begin
                                    res_data.status = ST_PARITY_ERROR;
                                end else begin
                                    res_data.status = ST_OK;
                                    res_data.data   = ok_data;
                                end
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            limit_reg     <= '0;
            elapsed_reg   <= '0;
            btc_reg       <= '0;
            bit_index_reg <= '0;
            shift_reg     <= '0;
            parity_reg    <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            limit_reg     <= limit_next;
            elapsed_reg   <= elapsed_next;
            btc_reg       <= btc_next;
            bit_index_reg <= bit_index_next;
            shift_reg     <= shift_next;
            parity_reg    <= parity_next;
        end
    end

endmodule

/* hw/rtl/ufr_result_queue.sv */
module ufr_result_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  ufr_pkg::ufr_result_t push_data,
    input  logic                 pop,
    output logic                 not_empty,
    output logic                 full,
    output ufr_pkg::ufr_result_t head
);
    import ufr_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ufr_result_t      entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign head      = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* bench/uart_frame_receiver_checker.sv */
package ufr_bench_pkg;

    localparam logic       OP_TICK       = 1'b0;
    localparam logic       OP_START      = 1'b1;
    localparam logic [1:0] PARITY_NONE   = 2'd0;
    localparam logic [1:0] PARITY_UNUSED = 2'd3;

endpackage

module uart_frame_receiver_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic                             pready,
    input  logic [ufr_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ufr_pkg::APB_DATA_W-1:0]   pwdata,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic                             s_operation,
    input  logic                             s_line_level,
    input  logic [ufr_pkg::TIMEOUT_MS_W-1:0] s_timeout_ms,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [1:0]                       m_status,
    input  logic [ufr_pkg::DATA_W-1:0]       m_received_data,
    output int                               fail_count,
    output int                               pending_results
);
    import ufr_pkg::*;
    import ufr_bench_pkg::*;

    localparam logic [PERIOD_W-1:0] ONE_TICK = PERIOD_W'(1);

    ufr_cfg_t               cfg;
    ufr_phase_t             rx_phase;
    logic [LIMIT_W-1:0]     timeout_ticks;
    logic [LIMIT_W-1:0]     hunt_ticks;
    logic [PERIOD_W-1:0]    sample_countdown;
    logic [BIT_INDEX_W-1:0] frame_bit;
    logic [SHIFT_W-1:0]     rx_shift;
    logic                   rx_parity;
    ufr_result_t            expected_receives[$];
    ufr_result_t            oldest;
    int                     mismatches = 0;

    function automatic logic parity_enabled();
        return cfg.parity_mode == PARITY_EVEN || cfg.parity_mode == PARITY_ODD;
    endfunction

    function automatic int unsigned payload_width();
        int unsigned n;
        n = cfg.data_bits_mode ? DATA_BITS_EIGHT : DATA_BITS_SEVEN;
        if (parity_enabled()) n++;
        if (n > MAX_PAYLOAD_BITS) n = MAX_PAYLOAD_BITS;
        return n;
    endfunction

    function automatic logic [PERIOD_W-1:0] ticks_per_bit();
        return (cfg.bit_period_ticks == '0) ? ONE_TICK : cfg.bit_period_ticks;
    endfunction

    task automatic close_receive(input ufr_status_t status, input logic [DATA_W-1:0] data);
        ufr_result_t outcome;
        outcome.status = status;
        outcome.data   = data;
        expected_receives.push_back(outcome);
        rx_phase = PH_IDLE;
    endtask

    task automatic sample_frame_bit(input logic line);
        int unsigned        n;
        logic [SHIFT_W-1:0] line_word;
        logic [SHIFT_W-1:0] top_bit;
        n = payload_width();
        line_word = SHIFT_W'(line);
        top_bit = SHIFT_W'(1);
        top_bit = top_bit << (n - 1);
        sample_countdown = ticks_per_bit();
        if (frame_bit == '0) begin
            if (line) close_receive(ST_FRAME_ERROR, '0);
            else frame_bit = BIT_INDEX_W'(1);
        end else if (frame_bit <= n) begin
            rx_shift = (rx_shift >> 1) | (line_word << (n - 1));
            rx_parity = rx_parity ^ line;
            frame_bit++;
        end else if (!line) begin
            close_receive(ST_FRAME_ERROR, '0);
        end else if (parity_enabled()) begin
            if (rx_parity) close_receive(ST_PARITY_ERROR, '0);
            else close_receive(ST_OK, rx_shift[DATA_W-1:0] & ~top_bit[DATA_W-1:0]);
        end else begin
            close_receive(ST_OK, rx_shift[DATA_W-1:0]);
        end
    endtask

    task automatic predict_rx_item(input logic op, input logic line,
                                   input logic [TIMEOUT_MS_W-1:0] tmo);
        logic [LIMIT_W-1:0] rate;
        logic [LIMIT_W-1:0] span;
        if (op == OP_START) begin
            rate = LIMIT_W'(cfg.ticks_per_ms);
            span = LIMIT_W'(tmo);
            timeout_ticks = rate * span;
            hunt_ticks = '0;
            sample_countdown = '0;
            frame_bit = '0;
            rx_shift = '0;
            rx_parity = 1'b0;
            if (tmo == '0) rx_phase = PH_HUNT_FOREVER;
            else rx_phase = PH_HUNT_TIMED;
        end else if (rx_phase == PH_HUNT_TIMED || rx_phase == PH_HUNT_FOREVER) begin
            if (rx_phase == PH_HUNT_TIMED && hunt_ticks >= timeout_ticks) begin
                close_receive(ST_TIMEOUT, '0);
            end else if (!line) begin
                rx_phase = PH_RECEIVE;
                frame_bit = '0;
                rx_shift = '0;
                rx_parity = (cfg.parity_mode == PARITY_ODD);
                sample_countdown = PERIOD_W'(ticks_per_bit() / 4);
                if (sample_countdown == '0) sample_frame_bit(line);
            end else if (rx_phase == PH_HUNT_TIMED) begin
                hunt_ticks++;
            end
        end else if (rx_phase == PH_RECEIVE) begin
            if (sample_countdown > 1) sample_countdown--;
            else sample_frame_bit(line);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg.bit_period_ticks = BIT_PERIOD_RESET;
            cfg.ticks_per_ms     = TPM_RESET;
            cfg.data_bits_mode   = DATA_BITS_RESET;
            cfg.parity_mode      = PARITY_RESET;
            rx_phase         = PH_IDLE;
            timeout_ticks    = '0;
            hunt_ticks       = '0;
            sample_countdown = '0;
            frame_bit        = '0;
            rx_shift         = '0;
            rx_parity        = 1'b0;
            expected_receives.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_ADDR_W-1:2])
                    REG_BIT_PERIOD:   cfg.bit_period_ticks = pwdata[PERIOD_W-1:0];
                    REG_TICKS_PER_MS: cfg.ticks_per_ms     = pwdata[TPM_W-1:0];
                    REG_DATA_BITS:    cfg.data_bits_mode   = pwdata[0];
                    REG_PARITY:       cfg.parity_mode      = pwdata[1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) predict_rx_item(s_operation, s_line_level, s_timeout_ms);
            if (m_valid && m_ready) begin
                if (expected_receives.size() == 0) begin
                    $error("unexpected result: status %0d, received_data 0x%02h",
                           m_status, m_received_data);
                    mismatches++;
                end else begin
                    oldest = expected_receives.pop_front();
                    if (m_status !== oldest.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               oldest.status, m_status);
                        mismatches++;
                    end
                    if (m_received_data !== oldest.data) begin
                        $error("received_data mismatch: expected 0x%02h, got 0x%02h",
                               oldest.data, m_received_data);
                        mismatches++;
                    end
                end
            end
        end
        fail_count      <= mismatches;
        pending_results <= expected_receives.size();
    end

endmodule

/* bench/uart_frame_receiver_test.sv */
// The top drives the block and gives the verdict; all prediction and comparison happen in
// the checker instance, which reports its failure count and the number of results it is
// still waiting for.
module uart_frame_receiver_test;
    import ufr_pkg::*;
    import ufr_bench_pkg::*;

    localparam int QUIET_LIMIT      = 4000;
    localparam int DRAIN_CYCLES     = 8;
    localparam int PHASE_ITEMS      = 225;
    localparam int SLOW_PHASE_ITEMS = 80;
    localparam int NUM_PHASES       = 9;

    // Ways a generated frame can be spoiled on purpose.
    typedef enum int {FLAW_NONE, FLAW_PARITY, FLAW_STOP, FLAW_GLITCH} frame_flaw_t;

    logic                    aclk    = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    psel    = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr   = '0;
    logic [APB_DATA_W-1:0]   pwdata  = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    s_valid      = 1'b0;
    logic                    s_ready;
    logic                    s_operation  = 1'b0;
    logic                    s_line_level = 1'b1;
    logic [TIMEOUT_MS_W-1:0] s_timeout_ms = '0;
    logic                    m_valid;
    logic                    m_ready      = 1'b0;
    logic [1:0]              m_status;
    logic [DATA_W-1:0]       m_received_data;

    int          fail_count;
    int          pending_results;
    int          quiet_cycles = 0;
    int unsigned items_sent   = 0;
    int unsigned gap_pct      = 0;
    int unsigned stall_pct    = 0;

    // The stimulus side keeps its own copy of the line format so that it can build frames.
    int unsigned bench_period = 9615;
    logic        bench_eight  = 1'b1;
    logic [1:0]  bench_parity = PARITY_NONE;

    // Settings of the random phases. The slow phase uses the longest bit period, so its
    // frames are always cut short and only hunting, restarts and timeouts are exercised.
    int unsigned phase_period[NUM_PHASES] = '{4, 5, 3, 6, 2, 7, 4, 1048575, 4};
    int unsigned phase_rate[NUM_PHASES]   = '{3, 1, 2, 7, 1, 4, 1000000, 1, 1};
    logic        phase_eight[NUM_PHASES]  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
                                             1'b1, 1'b0};
    logic [1:0]  phase_parity[NUM_PHASES] = '{PARITY_EVEN, PARITY_ODD, PARITY_ODD,
                                             PARITY_NONE, PARITY_UNUSED, PARITY_EVEN,
                                             PARITY_NONE, PARITY_EVEN, PARITY_ODD};

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    uart_frame_receiver dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_line_level    (s_line_level),
        .s_timeout_ms    (s_timeout_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_received_data (m_received_data)
    );

    uart_frame_receiver_checker frame_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_line_level    (s_line_level),
        .s_timeout_ms    (s_timeout_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_received_data (m_received_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // The result side stalls at random according to the current phase.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // The watchdog ends the run when no transfer has happened on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // One register write: setup cycle, then access cycle until pready, then an idle phase
    // so that back-to-back writes never reassign psel within the same time step.
    task automatic write_reg(input ufr_reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic apply_setting(input int unsigned period, input int unsigned rate,
                                 input logic eight, input logic [1:0] parity);
        write_reg(REG_BIT_PERIOD, period);
        write_reg(REG_TICKS_PER_MS, rate);
        write_reg(REG_DATA_BITS, APB_DATA_W'(eight));
        write_reg(REG_PARITY, APB_DATA_W'(parity));
        bench_period = period;
        bench_eight  = eight;
        bench_parity = parity;
    endtask

    // Offers one item and returns at the falling edge after its transfer. Random gaps
    // are inserted before the item when the sender is meant to idle.
    task automatic send_item(input logic op, input logic line,
                             input logic [TIMEOUT_MS_W-1:0] tmo);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_line_level <= line;
        s_timeout_ms <= tmo;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
    endtask

    // A tick carries a random timeout field, which the block ignores on ticks.
    task automatic tick(input logic line);
        send_item(OP_TICK, line, TIMEOUT_MS_W'($urandom_range(16'hFFFF)));
    endtask

    // The sender holds off until every expected result has been delivered. It always waits
    // for a falling edge, so s_valid is never dropped and raised in the same time step.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_results != 0);
    endtask

    // Before a register write, the block is also given time to finish any internal work.
    task automatic drain_receiver();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Sends one character as line samples, each frame bit held for one bit period (a glitch
    // sends a dip). A nonzero cut stops a longer frame after that many ticks, cutting it short.
    task automatic send_frame(input logic [7:0] data, input frame_flaw_t flaw,
                              input int unsigned cut);
        logic [10:0] levels;
        logic [7:0]  payload;
        int unsigned width;
        int unsigned hold;
        int unsigned sent;
        width   = bench_eight ? 8 : 7;
        payload = bench_eight ? data : (data & 8'h7F);
        hold    = (bench_period == 0) ? 1 : bench_period;
        sent    = 0;
        levels    = '1;
        levels[0] = 1'b0;
        for (int i = 0; i < width; i++) levels[1 + i] = payload[i];
        if (bench_parity == PARITY_EVEN || bench_parity == PARITY_ODD) begin
            // The parity bit makes the total count of ones even, or odd for odd parity.
            levels[1 + width] = (^payload) ^ (bench_parity == PARITY_ODD)
                                ^ (flaw == FLAW_PARITY);
            width++;
        end
        levels[1 + width] = (flaw != FLAW_STOP);
        if (flaw == FLAW_GLITCH) begin
            // A one-tick dip on the line, so the start bit is sampled high a little later
            // whenever the bit period is long enough to delay that sample.
            tick(1'b0);
            repeat ((hold < 8) ? hold : 8) tick(1'b1);
        end else begin
            for (int b = 0; b <= 1 + width; b++) begin
                for (int h = 0; h < hold; h++) begin
                    if (cut != 0 && sent == cut) return;
                    tick(levels[b]);
                    sent++;
                end
            end
        end
    endtask

    // Mostly forever or short timeouts; now and then a timeout anywhere in the field range.
    function automatic logic [TIMEOUT_MS_W-1:0] pick_timeout();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 30) return '0;
        if (pick < 90) return TIMEOUT_MS_W'($urandom_range(1, 12));
        return TIMEOUT_MS_W'($urandom_range(16'hFFFF));
    endfunction

    // One random stretch of traffic: mostly armed receives followed by a frame with random
    // content, some line noise, and some frames cut short by the next restart.
    task automatic run_random_sequence();
        int unsigned pick;
        int unsigned flaw_pick;
        int unsigned cut;
        frame_flaw_t flaw;
        logic        slow_line;
        pick      = $urandom_range(99);
        slow_line = (bench_period > 64);
        if (pick < 3) begin
            wait_for_results();
        end else if (pick < 70) begin
            send_item(OP_START, 1'($urandom_range(1)), pick_timeout());
            repeat ($urandom_range(8)) tick(1'b1);
            flaw_pick = $urandom_range(9);
            if (flaw_pick == 0) flaw = FLAW_PARITY;
            else if (flaw_pick == 1) flaw = FLAW_STOP;
            else if (flaw_pick == 2) flaw = FLAW_GLITCH;
            else flaw = FLAW_NONE;
            if (slow_line) cut = $urandom_range(1, 40);
            else if ($urandom_range(99) < 8) cut = $urandom_range(1, 30);
            else cut = 0;
            send_frame(8'($urandom_range(255)), flaw, cut);
        end else if (pick < 85) begin
            if ($urandom_range(1)) send_item(OP_START, 1'($urandom_range(1)), pick_timeout());
            repeat ($urandom_range(1, 20)) tick(1'($urandom_range(1)));
        end else begin
            send_item(OP_START, 1'($urandom_range(1)), pick_timeout());
            repeat ($urandom_range(3)) tick(1'b1);
            send_frame(8'($urandom_range(255)), FLAW_NONE, $urandom_range(1, 30));
        end
    endtask

    initial begin
        int unsigned phase_end;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part with a one-tick bit period: a tick while idle, a restart while
        // hunting after the largest timeout was latched, an all-ones character, and a
        // timeout after exactly one millisecond of one tick.
        apply_setting(1, 1, 1'b1, PARITY_EVEN);
        send_item(OP_TICK, 1'b0, 16'hFFFF);
        send_item(OP_START, 1'b1, 16'hFFFF);
        send_item(OP_START, 1'b0, 16'h0000);
        send_frame(8'hFF, FLAW_NONE, 0);
        send_item(OP_START, 1'b0, 16'd1);
        tick(1'b1);
        tick(1'b1);
        drain_receiver();

        // A zero bit period counts as one tick, a zero millisecond rate times out on the
        // first tick, and the unused parity code behaves as no parity.
        apply_setting(0, 0, 1'b0, PARITY_UNUSED);
        send_item(OP_START, 1'b1, 16'd7);
        tick(1'b1);
        send_item(OP_START, 1'b0, 16'd0);
        send_frame(8'h00, FLAW_NONE, 0);

        // Random phases, each under its own line format and idling pattern: none, sender
        // gaps, receiver stalls, then both together.
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_receiver();
            apply_setting(phase_period[p], phase_rate[p], phase_eight[p], phase_parity[p]);
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 46; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 46; end
                default: begin gap_pct = 35; stall_pct = 35; end
            endcase
            phase_end = items_sent + ((phase_period[p] > 64) ? SLOW_PHASE_ITEMS : PHASE_ITEMS);
            while (items_sent < phase_end) run_random_sequence();
        end

        drain_receiver();
        if (fail_count == 0 && pending_results == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/ufr_pkg.sv
hw/rtl/ufr_config_regs.sv
hw/rtl/ufr_frame_core.sv
hw/rtl/ufr_result_queue.sv
hw/rtl/uart_frame_receiver.sv
bench/uart_frame_receiver_checker.sv
bench/uart_frame_receiver_test.sv
